// File: rtl/core/fcm_pkg.sv
// Package with shared types and codes for the allocation table chain manager.
`timescale 1ns / 1ps

package fcm_pkg;

  // Operation codes carried on func
  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_READ   = 3'd1,
    FN_FIND   = 3'd2,
    FN_START  = 3'd3,
    FN_SPLICE = 3'd4,
    FN_FREE   = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_NOFREE  = 2'd2,
    ST_WALK    = 2'd3
  } status_t;

  // Link that ends a chain
  localparam logic [15:0] END_MARK = 16'hFFFF;

  // Width used for limit compares: holds any 16-bit index and the limit itself
  localparam int CMP_W = 17;

  // Reset value of the limit register
  localparam logic [13:0] LIMIT_RESET = 14'd8192;

endpackage

// File: rtl/core/fat_chain_manager.sv
// Allocation table chain manager: link table, operation sequencer and handshakes.
// Load items and items refused at dispatch end there; read and start chain read the entry once,
// splice reads new entry and predecessor, find free reads up from entry 1, free chain zeroes links.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// registered, and a result held back by out_stall parks in a slot and stalls the input.
// Reset: synchronous; a clearing pass zeroes every table entry, no item taken meanwhile.
`timescale 1ns / 1ps

module fat_chain_manager #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [15:0] entry_index,
  input  logic [15:0] operand,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] result_value
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = fcm_pkg::CMP_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RD_A,
    S_RD_B,
    S_WR_B,
    S_WALK,
    S_WALK_RD
  } state_t;

  // Sequencer registers
  state_t          state, state_next;
  logic [2:0]      fn;
  logic [15:0]     idx;
  logic [15:0]     opv;
  logic [15:0]     cur, cur_next;
  logic [15:0]     hops, hops_next;
  logic [AW-1:0]   clr_addr;
  logic [13:0]     table_limit;
  logic            done;
  logic [1:0]      res_status;
  logic [15:0]     res_value;
  logic            res_pend;

  // Link memory port
  logic [15:0]     link_mem [TABLE_DEPTH];
  logic [15:0]     rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  // Effective limit and range checks
  logic [CW-1:0]   lim;
  logic            idx_ok;
  logic            opv_ok;
  logic            cur_ok;
  logic            hops_ok;
  logic            accept;
  logic            out_free;

  assign lim = ({3'b000, table_limit} < CW'(TABLE_DEPTH)) ? {3'b000, table_limit}
                                                          : CW'(TABLE_DEPTH);
  assign idx_ok  = {1'b0, idx} < lim;
  assign opv_ok  = {1'b0, opv} < lim;
  assign cur_ok  = {1'b0, cur} < lim;
  assign hops_ok = {1'b0, hops} < lim;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || res_pend;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Sequence one operation over the memory port
  always_comb begin
    state_next = state;
    cur_next   = cur;
    hops_next  = hops;
    done       = 1'b0;
    res_status = fcm_pkg::ST_REFUSED;
    res_value  = 16'd0;
    mem_we     = 1'b0;
    mem_waddr  = idx[AW-1:0];
    mem_wdata  = 16'd0;
    mem_re     = 1'b0;
    mem_raddr  = idx[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_DISPATCH;
          cur_next   = (func == fcm_pkg::FN_FIND) ? 16'd1 : entry_index;
          hops_next  = 16'd0;
        end
      end
      S_DISPATCH: begin
        case (fn)
          fcm_pkg::FN_LOAD: begin
            done = 1'b1;
            if (idx_ok) begin
              mem_we     = 1'b1;
              mem_wdata  = opv;
              res_status = fcm_pkg::ST_OK;
            end
          end
          fcm_pkg::FN_READ, fcm_pkg::FN_START: begin
            if (idx_ok) begin
              mem_re     = 1'b1;
              state_next = S_RD_A;
            end else begin
              done = 1'b1;
            end
          end
          fcm_pkg::FN_SPLICE: begin
            if (idx_ok && opv_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = opv[AW-1:0];
              state_next = S_RD_A;
            end else begin
              done = 1'b1;
            end
          end
          fcm_pkg::FN_FIND, fcm_pkg::FN_FREE: begin
            state_next = S_WALK;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_RD_A: begin
        case (fn)
          fcm_pkg::FN_READ: begin
            done       = 1'b1;
            res_status = fcm_pkg::ST_OK;
            res_value  = rd_data;
          end
          fcm_pkg::FN_START: begin
            done = 1'b1;
            if (rd_data == 16'd0) begin
              mem_we     = 1'b1;
              mem_wdata  = fcm_pkg::END_MARK;
              res_status = fcm_pkg::ST_OK;
            end
          end
          default: begin
            // splice: new entry must be free, then fetch the predecessor
            if (rd_data == 16'd0) begin
              mem_re     = 1'b1;
              state_next = S_RD_B;
            end else begin
              done = 1'b1;
            end
          end
        endcase
      end
      S_RD_B: begin
        // predecessor must be in use; new entry takes over its link
        if (rd_data != 16'd0) begin
          mem_we     = 1'b1;
          mem_waddr  = opv[AW-1:0];
          mem_wdata  = rd_data;
          state_next = S_WR_B;
        end else begin
          done = 1'b1;
        end
      end
      S_WR_B: begin
        mem_we     = 1'b1;
        mem_wdata  = opv;
        done       = 1'b1;
        res_status = fcm_pkg::ST_OK;
      end
      S_WALK: begin
        mem_raddr = cur[AW-1:0];
        if (fn == fcm_pkg::FN_FIND) begin
          if (cur_ok) begin
            mem_re     = 1'b1;
            state_next = S_WALK_RD;
          end else begin
            done       = 1'b1;
            res_status = fcm_pkg::ST_NOFREE;
          end
        end else begin
          res_value = hops;
          if (cur == fcm_pkg::END_MARK) begin
            done       = 1'b1;
            res_status = fcm_pkg::ST_OK;
          end else if (!cur_ok) begin
            done       = 1'b1;
            res_status = fcm_pkg::ST_REFUSED;
          end else if (!hops_ok) begin
            done       = 1'b1;
            res_status = fcm_pkg::ST_WALK;
          end else begin
            mem_re     = 1'b1;
            state_next = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        if (fn == fcm_pkg::FN_FIND) begin
          if (rd_data == 16'd0) begin
            done       = 1'b1;
            res_status = fcm_pkg::ST_OK;
            res_value  = cur;
          end else begin
            cur_next   = cur + 16'd1;
            state_next = S_WALK;
          end
        end else begin
          // zero this entry and follow its link
          mem_we     = 1'b1;
          mem_waddr  = cur[AW-1:0];
          cur_next   = rd_data;
          hops_next  = hops + 16'd1;
          state_next = S_WALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (done) begin
      state_next = S_IDLE;
    end
  end

  // Hold link memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= link_mem[mem_raddr];
    end
  end

  // Hold state, operands, pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      table_limit <= fcm_pkg::LIMIT_RESET;
      res_pend    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        table_limit <= cfg_data;
      end
      // load a new or parked result when the register is free, else drop a taken one
      if (done) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          res_pend <= 1'b1;
        end
      end else if (res_pend && out_free) begin
        res_pend  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    cur  <= cur_next;
    hops <= hops_next;
    if (accept) begin
      fn  <= func;
      idx <= entry_index;
      opv <= operand;
    end
    if (done && out_free) begin
      status       <= res_status;
      result_value <= res_value;
    end else if (done) begin
      // park the result until the output register drains
      idx <= res_value;
      opv <= {14'd0, res_status};
    end else if (res_pend && out_free) begin
      status       <= opv[1:0];
      result_value <= idx;
    end
  end

endmodule

// File: test/tb_fat_chain_manager.sv
// Self-checking testbench for the allocation table chain manager.
`timescale 1ns / 1ps

module tb_fat_chain_manager;

  localparam int TBL_DEPTH = 8192;
  localparam int CYCLE_LIMIT = 10_000_000;
  // Func codes the block does not implement
  localparam logic [2:0] FN_RSVD_A = 3'd6;
  localparam logic [2:0] FN_RSVD_B = 3'd7;

  typedef struct {
    logic [2:0]  fn;
    logic [15:0] idx;
    logic [15:0] opnd;
  } table_op_t;

  typedef struct {
    fcm_pkg::status_t st;
    logic [15:0]      val;
  } table_reply_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [15:0] entry_index = '0;
  logic [15:0] operand = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] result_value;

  // Mirror of the block state
  bit [15:0]   link_mirror [TBL_DEPTH];
  bit [13:0]   limit_mirror = fcm_pkg::LIMIT_RESET;

  table_op_t    outgoing_ops [$];
  table_reply_t awaited_replies [$];
  table_op_t    next_op;
  table_op_t    seen_op;
  table_reply_t got_reply;

  logic        in_taken = 1'b0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          drain_hold = 1'b0;
  int unsigned stall_tick = 0;
  rx_mode_t    rx_mode = RX_FREE;

  fat_chain_manager #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .entry_index(entry_index),
    .operand(operand),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .result_value(result_value)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one operation to the mirror and return the reply it gives
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    int lim;
    int ix;
    int ov;
    int cur;
    int hops;
    int i;
    bit done;
    logic [15:0] nxt;
    lim = (int'(limit_mirror) < TBL_DEPTH) ? int'(limit_mirror) : TBL_DEPTH;
    ix = int'(op.idx);
    ov = int'(op.opnd);
    r.st = fcm_pkg::ST_REFUSED;
    r.val = '0;
    case (op.fn)
      fcm_pkg::FN_LOAD: begin
        if (ix < lim) begin
          link_mirror[ix] = op.opnd;
          r.st = fcm_pkg::ST_OK;
        end
      end
      fcm_pkg::FN_READ: begin
        if (ix < lim) begin
          r.val = link_mirror[ix];
          r.st = fcm_pkg::ST_OK;
        end
      end
      fcm_pkg::FN_FIND: begin
        r.st = fcm_pkg::ST_NOFREE;
        done = 1'b0;
        for (i = 1; i < lim && !done; i++) begin
          if (link_mirror[i] == 16'd0) begin
            r.val = i[15:0];
            r.st = fcm_pkg::ST_OK;
            done = 1'b1;
          end
        end
      end
      fcm_pkg::FN_START: begin
        if (ix < lim && link_mirror[ix] == 16'd0) begin
          link_mirror[ix] = fcm_pkg::END_MARK;
          r.st = fcm_pkg::ST_OK;
        end
      end
      fcm_pkg::FN_SPLICE: begin
        if (ix < lim && ov < lim && link_mirror[ov] == 16'd0 &&
            link_mirror[ix] != 16'd0) begin
          link_mirror[ov] = link_mirror[ix];
          link_mirror[ix] = op.opnd;
          r.st = fcm_pkg::ST_OK;
        end
      end
      fcm_pkg::FN_FREE: begin
        // Walk the chain, zeroing links; stop on a bad index or too many hops
        r.st = fcm_pkg::ST_OK;
        cur = ix;
        hops = 0;
        done = 1'b0;
        while (!done && cur != int'(fcm_pkg::END_MARK)) begin
          if (cur >= lim) begin
            r.st = fcm_pkg::ST_REFUSED;
            done = 1'b1;
          end else if (hops >= lim) begin
            r.st = fcm_pkg::ST_WALK;
            done = 1'b1;
          end else begin
            nxt = link_mirror[cur];
            link_mirror[cur] = 16'd0;
            hops++;
            cur = int'(nxt);
          end
        end
        r.val = hops[15:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_error(string what, table_reply_t want, logic [1:0] gs,
                            logic [15:0] gv);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR %s at %0t: expected status %0d value %h, got status %0d value %h",
               what, $time, want.st, want.val, gs, gv);
    end
  endtask

  // Monitor: check results, predict accepted items, track limit writes
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        limit_mirror = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          got_reply.st = fcm_pkg::ST_OK;
          got_reply.val = '0;
          note_error("unexpected result", got_reply, status, result_value);
        end else begin
          got_reply = awaited_replies.pop_front();
          if (status !== got_reply.st || result_value !== got_reply.val) begin
            note_error("result mismatch", got_reply, status, result_value);
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen_op.fn = func;
        seen_op.idx = entry_index;
        seen_op.opnd = operand;
        awaited_replies.push_back(apply_table_op(seen_op));
        n_accepted++;
      end
    end
  end

  // Driver: send queued items in bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled item
    end else if (drain_hold) begin
      in_valid <= 1'b0;
      if (awaited_replies.size() == 0) begin
        drain_hold = 1'b0;
      end
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (outgoing_ops.size() > 0) begin
      next_op = outgoing_ops.pop_front();
      func <= next_op.fn;
      entry_index <= next_op.idx;
      operand <= next_op.opnd;
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 11) == 0) begin
          drain_hold = 1'b1;
        end
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern that switches at random among free, random, periodic and long modes
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 64 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        RX_PERIODIC: out_stall <= (stall_tick % 5) < 2;
        default:     out_stall <= (stall_tick % 32) < 20;
      endcase
    end
  end

  task automatic push_op(logic [2:0] fn, logic [15:0] ix, logic [15:0] op);
    table_op_t t;
    t.fn = fn;
    t.idx = ix;
    t.opnd = op;
    outgoing_ops.push_back(t);
    n_queued++;
  endtask

  // Wait until every queued item has been taken and answered
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || awaited_replies.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(logic [13:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_index(int lim, int win);
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return 16'($urandom_range(0, win - 1));
    if (r == 15) return 16'(lim - 1);
    if (r == 16) return 16'(lim);
    if (r == 17) return fcm_pkg::END_MARK;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_link(int lim, int win);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, win - 1));
    if (r < 8) return fcm_pkg::END_MARK;
    if (r == 8) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  // One random phase: mostly chain build/walk sequences, some noise
  task automatic run_phase(logic [13:0] limit_val, int n_items, bit noise_free);
    int lim;
    int win;
    int head;
    int last;
    int n_splice;
    int k;
    int stop_at;
    logic [2:0] fn;
    write_limit(limit_val);
    lim = (int'(limit_val) < TBL_DEPTH) ? int'(limit_val) : TBL_DEPTH;
    win = (lim > 96) ? 96 : lim;
    stop_at = n_queued + n_items;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        head = (win > 1) ? $urandom_range(1, win - 1) : 0;
        last = head;
        if ($urandom_range(0, 4) == 0) begin
          push_op(fcm_pkg::FN_FIND, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        end
        push_op(fcm_pkg::FN_START, 16'(head), 16'($urandom_range(0, 65535)));
        n_splice = $urandom_range(0, 5);
        for (k = 0; k < n_splice; k++) begin
          if ($urandom_range(0, 1) == 0) begin
            last = $urandom_range(0, 1) ? head : last;
          end
          push_op(fcm_pkg::FN_SPLICE, 16'(last),
                  ($urandom_range(0, 7) == 0) ? pick_index(lim, win)
                                              : 16'($urandom_range(0, win - 1)));
          last = int'(outgoing_ops[$].opnd);
        end
        push_op(fcm_pkg::FN_READ, 16'(head), 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) != 0) begin
          push_op(fcm_pkg::FN_FREE, 16'(head), 16'($urandom_range(0, 65535)));
        end
      end else begin
        fn = 3'($urandom_range(0, 7));
        if (fn == fcm_pkg::FN_FREE && !noise_free) begin
          fn = fcm_pkg::FN_READ;
        end
        push_op(fn, pick_index(lim, win), pick_link(lim, win));
      end
    end
    wait_drained();
  endtask

  // Timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full-size table: range edges, every operation, refusals, walk stops
    write_limit(fcm_pkg::LIMIT_RESET);
    push_op(fcm_pkg::FN_READ, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_READ, 16'd8191, 16'hFFFF);
    push_op(fcm_pkg::FN_READ, 16'd8192, 16'd0);
    push_op(fcm_pkg::FN_READ, 16'hFFFF, 16'h5555);
    push_op(fcm_pkg::FN_LOAD, 16'd8191, fcm_pkg::END_MARK);
    push_op(fcm_pkg::FN_LOAD, 16'd5, 16'h5555);
    push_op(fcm_pkg::FN_LOAD, 16'd6, 16'hAAAA);
    push_op(fcm_pkg::FN_READ, 16'd6, 16'h0000);
    push_op(fcm_pkg::FN_FIND, 16'hAAAA, 16'h5555);
    push_op(fcm_pkg::FN_START, 16'd1, 16'd0);
    push_op(fcm_pkg::FN_START, 16'd1, 16'd0);
    push_op(fcm_pkg::FN_SPLICE, 16'd1, 16'd2);
    push_op(fcm_pkg::FN_SPLICE, 16'd1, 16'd8191);
    push_op(fcm_pkg::FN_SPLICE, 16'd3, 16'd4);
    push_op(fcm_pkg::FN_SPLICE, 16'd1, 16'd8192);
    push_op(fcm_pkg::FN_SPLICE, 16'd8192, 16'd4);
    push_op(fcm_pkg::FN_READ, 16'd1, 16'd0);
    push_op(fcm_pkg::FN_FIND, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_FREE, fcm_pkg::END_MARK, 16'd0);
    push_op(fcm_pkg::FN_FREE, 16'd1, 16'd0);
    // link past the limit stops the walk
    push_op(fcm_pkg::FN_LOAD, 16'd10, 16'd8192);
    push_op(fcm_pkg::FN_FREE, 16'd10, 16'd0);
    // loop of two links runs into the hop limit
    push_op(fcm_pkg::FN_LOAD, 16'd20, 16'd21);
    push_op(fcm_pkg::FN_LOAD, 16'd21, 16'd20);
    push_op(fcm_pkg::FN_FREE, 16'd20, 16'd0);
    push_op(FN_RSVD_A, 16'hFFFF, 16'hFFFF);
    push_op(FN_RSVD_B, 16'd0, 16'd0);
    wait_drained();

    // Zero limit refuses every index
    write_limit(14'd0);
    push_op(fcm_pkg::FN_FIND, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_READ, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_START, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_FREE, fcm_pkg::END_MARK, 16'd0);
    push_op(fcm_pkg::FN_FREE, 16'd0, 16'd0);
    wait_drained();

    // Limit above the table depth acts as the depth
    write_limit(14'h3FFF);
    push_op(fcm_pkg::FN_READ, 16'd8191, 16'd0);
    push_op(fcm_pkg::FN_READ, 16'd8192, 16'd0);
    wait_drained();

    // Single entry: nothing to find, entry 0 still usable
    write_limit(14'd1);
    push_op(fcm_pkg::FN_FIND, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_START, 16'd0, 16'd0);
    push_op(fcm_pkg::FN_FREE, 16'd0, 16'd0);
    wait_drained();

    // Random phases, mostly small limits
    run_phase(14'd2, 60, 1'b1);
    run_phase(14'd9, 66, 1'b1);
    run_phase(14'd16, 66, 1'b1);
    run_phase(14'd33, 66, 1'b1);
    run_phase(14'd64, 66, 1'b1);
    run_phase(14'h3FFF, 20, 1'b0);
    run_phase(14'd100, 66, 1'b1);
    run_phase(14'd255, 66, 1'b1);
    run_phase(fcm_pkg::LIMIT_RESET, 20, 1'b0);
    run_phase(14'($urandom_range(1, 512)), 66, 1'b1);
    run_phase(14'd40, 66, 1'b1);
    run_phase(14'd12, 66, 1'b1);

    repeat (40) @(negedge clk);
    if (awaited_replies.size() != 0) begin
      $display("ERROR %0d results never arrived", awaited_replies.size());
      n_errors += awaited_replies.size();
    end
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
